[src/indexed_list_store_top_assert.svh]
// assertion macros used by the list store controller
`ifndef INDEXED_LIST_STORE_TOP_ASSERT_SVH
`define INDEXED_LIST_STORE_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define ILS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define ILS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ILS_ASSERT_IMP(lbl, ante, cons, msg)
`define ILS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[src/ils_pkg.sv]
package ils_pkg;

  localparam int POS_W = 6;
  localparam int OUT_CNT_W = 6;

  typedef enum logic [3:0] {
    OP_PUSH_FRONT = 4'd0,
    OP_PUSH_BACK  = 4'd1,
    OP_INSERT     = 4'd2,
    OP_POP_FRONT  = 4'd3,
    OP_POP_BACK   = 4'd4,
    OP_REMOVE     = 4'd5,
    OP_GET        = 4'd6,
    OP_SET        = 4'd7,
    OP_WALK_FWD   = 4'd8,
    OP_WALK_BWD   = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    EDIT_NONE   = 2'd0,
    EDIT_INSERT = 2'd1,
    EDIT_REMOVE = 2'd2,
    EDIT_SET    = 2'd3
  } edit_kind_t;

  typedef struct packed {
    edit_kind_t       kind;
    logic [POS_W-1:0] pos;
  } edit_t;

endpackage

[src/ils_cell.sv]
module ils_cell
  import ils_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int IDX = 0
) (
  input  logic                  clk,
  input  edit_t                 edit,
  input  logic [DATA_WIDTH-1:0] value,
  input  logic [DATA_WIDTH-1:0] left_q,
  input  logic [DATA_WIDTH-1:0] right_q,
  output logic [DATA_WIDTH-1:0] q
);

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

  always_ff @(posedge clk) begin
    case (edit.kind)
      EDIT_INSERT: begin
        // cells above the slot take their left neighbor
        if (MY_IDX > edit.pos) begin
          q <= left_q;
        end else if (MY_IDX == edit.pos) begin
          q <= value;
        end
      end
      EDIT_REMOVE: begin
        if (MY_IDX >= edit.pos) begin
          q <= right_q;
        end
      end
      EDIT_SET: begin
        if (MY_IDX == edit.pos) begin
          q <= value;
        end
      end
      default: begin
        q <= q;
      end
    endcase
  end

endmodule

[src/ils_ctrl.sv]
`include "indexed_list_store_top_assert.svh"

module ils_ctrl
  import ils_pkg::*;
#(
  parameter int CAPACITY = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [3:0]            in_op,
  input  logic [POS_W-1:0]      in_pos,
  input  logic [DATA_WIDTH-1:0] cell_q [CAPACITY],
  output edit_t                 edit,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           out_read_value,
  output logic [1:0]            out_status,
  output logic [OUT_CNT_W-1:0]  out_count,
  output logic                  out_last
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int KW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic {S_IDLE, S_BUSY} state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [CW-1:0] walk_left;
  logic [IW-1:0] walk_idx;
  logic          walk_fwd;

  logic [KW-1:0] pos_k, cnt_k, cap_k, ins_k, rem_k, cnt_next_k, walk_idx0_k;
  logic          do_ins, do_rem, get_ok, walk_start, accept;
  status_t       st;
  edit_kind_t    ek;
  logic [KW-1:0] ep_k;
  logic [IW-1:0] rd_idx;
  logic [63:0]   rd64;
  logic [31:0]   rd32;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign pos_k    = KW'(in_pos);
  assign cnt_k    = KW'(count);
  assign cap_k    = KW'(CAPACITY);

  always_comb begin
    st          = ST_OK;
    do_ins      = 1'b0;
    do_rem      = 1'b0;
    get_ok      = 1'b0;
    walk_start  = 1'b0;
    ins_k       = pos_k;
    rem_k       = pos_k;
    ek          = EDIT_NONE;
    ep_k        = pos_k;
    cnt_next_k  = cnt_k;
    case (op_t'(in_op))
      OP_PUSH_FRONT: begin
        do_ins = 1'b1;
        ins_k  = '0;
      end
      OP_PUSH_BACK: begin
        do_ins = 1'b1;
        ins_k  = cnt_k;
      end
      OP_INSERT: begin
        do_ins = 1'b1;
      end
      OP_POP_FRONT: begin
        do_rem = 1'b1;
        rem_k  = '0;
      end
      OP_POP_BACK: begin
        do_rem = 1'b1;
        rem_k  = cnt_k - KW'(1);
      end
      OP_REMOVE: begin
        do_rem = 1'b1;
      end
      OP_GET: begin
        if (pos_k >= cnt_k) begin
          st = ST_RANGE;
        end else begin
          get_ok = 1'b1;
        end
      end
      OP_SET: begin
        if (pos_k >= cnt_k) begin
          st = ST_RANGE;
        end else begin
          ek = EDIT_SET;
        end
      end
      OP_WALK_FWD, OP_WALK_BWD: begin
        if (cnt_k == '0) begin
          st = ST_EMPTY;
        end else begin
          walk_start = 1'b1;
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase

    if (do_ins) begin
      ep_k = ins_k;
      if (ins_k > cnt_k) begin
        st = ST_RANGE;
      end else if (cnt_k >= cap_k) begin
        st = ST_FULL;
      end else begin
        ek         = EDIT_INSERT;
        cnt_next_k = cnt_k + KW'(1);
      end
    end

    if (do_rem) begin
      ep_k = rem_k;
      if (cnt_k == '0 && (op_t'(in_op) == OP_POP_FRONT || op_t'(in_op) == OP_POP_BACK)) begin
        st = ST_EMPTY;
      end else if (rem_k >= cnt_k) begin
        st = ST_RANGE;
      end else begin
        ek         = EDIT_REMOVE;
        cnt_next_k = cnt_k - KW'(1);
      end
    end
  end

  // cells change only on the cycle the request is taken
  assign edit.kind = accept ? ek : EDIT_NONE;
  assign edit.pos  = ep_k[POS_W-1:0];

  // read port: get position, first walk element, then the walk pointer
  assign walk_idx0_k = (op_t'(in_op) == OP_WALK_FWD) ? '0 : (cnt_k - KW'(1));

  always_comb begin
    if (state == S_BUSY) begin
      rd_idx = walk_idx;
    end else if (walk_start) begin
      rd_idx = walk_idx0_k[IW-1:0];
    end else begin
      rd_idx = pos_k[IW-1:0];
    end
  end

  assign rd64 = 64'(cell_q[rd_idx]);
  assign rd32 = rd64[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state          <= S_BUSY;
            count          <= cnt_next_k[CW-1:0];
            out_valid      <= 1'b1;
            out_status     <= st;
            out_count      <= cnt_next_k[OUT_CNT_W-1:0];
            out_read_value <= (get_ok || walk_start) ? rd32 : 32'd0;
            out_last       <= !(walk_start && (cnt_k > KW'(1)));
            walk_fwd       <= (op_t'(in_op) == OP_WALK_FWD);
            walk_left      <= count - CW'(1);
            walk_idx       <= (op_t'(in_op) == OP_WALK_FWD) ? IW'(1)
                                                             : IW'(cnt_k - KW'(2));
          end
        end
        S_BUSY: begin
          if (out_ready) begin
            if (out_last) begin
              state     <= S_IDLE;
              out_valid <= 1'b0;
            end else begin
              out_read_value <= rd32;
              out_last       <= (walk_left == CW'(1));
              walk_left      <= walk_left - CW'(1);
              walk_idx       <= walk_fwd ? (walk_idx + IW'(1)) : (walk_idx - IW'(1));
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ILS_ASSERT_IMP(a_count_bound, 1'b1, count <= CW'(CAPACITY), "count above capacity")
  `ILS_ASSERT_IMP(a_ready_excl, in_ready, !out_valid, "request taken while result pending")
  `ILS_ASSERT_NXT(a_count_hold, !accept, $stable(count), "count changed without a request")
  `ILS_ASSERT_IMP(a_walk_left, out_valid && !out_last, walk_left != '0,
                  "walk continues with no elements left")

endmodule

[src/indexed_list_store_top.sv]
// ordered list store built from a row of shifting cells
// result: registered when the request is taken
// throughput: edits and reads take the request, then deliver; no new request is taken until it is accepted;
//   a walk of n elements delivers one result per cycle, gated by m_axis_tready
// reset: rst synchronous active high empties the list; element storage is not cleared
module indexed_list_store_top
  import ils_pkg::*;
#(
  parameter int CAPACITY = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // operation[3:0], position[9:4], value[41:10]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // read_value[31:0], status[33:32], element_count[39:34]
  output logic        m_axis_tlast
);

  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
  logic [DATA_WIDTH-1:0] din;
  logic [63:0]           v64;
  edit_t                 edit;
  logic [31:0]           rd_value;
  logic [1:0]            rd_status;
  logic [OUT_CNT_W-1:0]  rd_count;

  assign v64 = 64'(s_axis_tdata[41:10]);
  assign din = v64[DATA_WIDTH-1:0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_q, right_q;
    if (i == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_mid_l
      assign left_q = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_mid_r
      assign right_q = cell_q[i+1];
    end
    ils_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .IDX       (i)
    ) u_cell (
      .clk    (clk),
      .edit   (edit),
      .value  (din),
      .left_q (left_q),
      .right_q(right_q),
      .q      (cell_q[i])
    );
  end

  ils_ctrl #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_op         (s_axis_tdata[3:0]),
    .in_pos        (s_axis_tdata[9:4]),
    .cell_q        (cell_q),
    .edit          (edit),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_read_value(rd_value),
    .out_status    (rd_status),
    .out_count     (rd_count),
    .out_last      (m_axis_tlast)
  );

  assign m_axis_tdata = {rd_count, rd_status, rd_value};

endmodule
